@@ rtl/mrfe_pkg.sv @@
// Shared types, codes and constants for the Modbus RTU master frame engine.
// Holds the CRC-16/MODBUS byte fold used by the transmit and receive sides.
// No dependencies.
package mrfe_pkg;

  localparam int MAX_FRAME = 8;
  localparam int REQ_LEN   = 8;
  localparam int RX_CAP    = (MAX_FRAME < REQ_LEN) ? MAX_FRAME : REQ_LEN;
  localparam int IDX_W     = $clog2(MAX_FRAME + 1);
  localparam int SLOT_W    = $clog2(MAX_FRAME);
  localparam int SEQ_W     = $clog2(REQ_LEN);

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] ADDR_ALL_ONES = 16'hFFFF;
  localparam logic [15:0] ADDR_MAX      = 16'h00F7;
  localparam logic [15:0] ADDR_MIN      = 16'h0001;
  localparam logic [7:0]  ADDR_DEFAULT  = 8'h01;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;

  localparam logic [1:0] CMD_SEND  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_BYTE  = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SHORT  = 2'd1;
  localparam logic [1:0] ST_CRC    = 2'd2;
  localparam logic [1:0] ST_ECHO   = 2'd3;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef logic [REQ_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] count;
    logic [1:0]       status;
  } rx_result_t;

  // Fold one byte into a CRC-16/MODBUS remainder, one bit per step.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/mrfe_rx.sv @@
// Receive tracker of the Modbus RTU master frame engine: stores bytes, runs the
// lagged CRC, counts ticks and forms the one status result at the end.
// Depends on mrfe_pkg.
module mrfe_rx import mrfe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic             accept,
  input  logic [1:0]       command,
  input  logic             check_echo,
  input  logic [3:0]       expect_length,
  input  logic [7:0]       rx_byte,
  input  frame_t           sent_frame,
  output rx_result_t       rx_res
);

  logic [15:0]      timeout_r;
  logic [7:0]       rx_store_r [MAX_FRAME];
  logic [IDX_W-1:0] rx_index_r, rx_index_nxt;
  logic [IDX_W-1:0] awaited_r, awaited_nxt;
  logic             receiving_r, receiving_nxt;
  logic             echo_armed_r, echo_armed_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic [15:0]      lagged_crc_r, lagged_crc_nxt;
  logic [7:0]       newest_r, newest_nxt;
  logic [7:0]       older_r, older_nxt;

  logic [7:0]       store_p [MAX_FRAME];
  logic             wr_en;
  logic             do_finish;
  logic [IDX_W-1:0] idx_p;
  logic [15:0]      elapsed_p;
  logic [IDX_W-1:0] start_len;
  logic             crc_ok;
  logic             echo_bad;
  logic [1:0]       fin_status;

  // Byte and tick handling on the receive state
  always_comb begin
    wr_en     = 1'b0;
    do_finish = 1'b0;
    idx_p     = rx_index_r;
    elapsed_p = elapsed_r;
    lagged_crc_nxt = lagged_crc_r;
    newest_nxt = newest_r;
    older_nxt  = older_r;
    if (accept && receiving_r) begin
      unique case (command)
        CMD_BYTE: begin
          if (rx_index_r >= awaited_r || rx_index_r >= IDX_W'(MAX_FRAME)) begin
            do_finish = 1'b1;
          end else begin
            if (rx_index_r >= IDX_W'(2)) begin
              lagged_crc_nxt = crc_fold(lagged_crc_r, older_r);
            end
            wr_en      = 1'b1;
            newest_nxt = rx_byte;
            older_nxt  = newest_r;
            idx_p      = rx_index_r + IDX_W'(1);
            do_finish  = (idx_p >= awaited_r);
          end
        end
        CMD_TICK: begin
          if (elapsed_r != 16'hFFFF) begin
            elapsed_p = elapsed_r + 16'd1;
          end
          do_finish = (elapsed_p >= timeout_r);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_FRAME; i++) begin
      store_p[i] = (wr_en && rx_index_r[SLOT_W-1:0] == SLOT_W'(i)) ? rx_byte : rx_store_r[i];
    end
  end

  // Status of a finishing receive, judged on the state after this request
  always_comb begin
    crc_ok = (idx_p > IDX_W'(2)) && (idx_p <= IDX_W'(MAX_FRAME)) &&
             ({newest_nxt, older_nxt} == lagged_crc_nxt);
    echo_bad = (idx_p != IDX_W'(REQ_LEN));
    for (int i = 0; i < RX_CAP; i++) begin
      if (store_p[i] != sent_frame[i]) begin
        echo_bad = 1'b1;
      end
    end
    priority if (idx_p < awaited_r) begin
      fin_status = ST_SHORT;
    end else if (!crc_ok) begin
      fin_status = ST_CRC;
    end else if (echo_armed_r && echo_bad) begin
      fin_status = ST_ECHO;
    end else begin
      fin_status = ST_OK;
    end
  end

  assign start_len = (expect_length > 4'(RX_CAP)) ? IDX_W'(RX_CAP) : IDX_W'(expect_length);

  // Arming and result selection
  always_comb begin
    rx_index_nxt   = idx_p;
    awaited_nxt    = awaited_r;
    receiving_nxt  = receiving_r;
    echo_armed_nxt = echo_armed_r;
    elapsed_nxt    = elapsed_p;
    rx_res         = '0;
    if (do_finish) begin
      receiving_nxt  = 1'b0;
      echo_armed_nxt = 1'b0;
      rx_res.valid   = 1'b1;
      rx_res.count   = crc_ok ? idx_p : '0;
      rx_res.status  = fin_status;
    end
    if (accept && command == CMD_SEND) begin
      receiving_nxt  = check_echo;
      echo_armed_nxt = check_echo;
      if (check_echo) begin
        awaited_nxt  = IDX_W'(RX_CAP);
        rx_index_nxt = '0;
        elapsed_nxt  = '0;
      end
    end
    if (accept && command == CMD_START) begin
      awaited_nxt    = start_len;
      rx_index_nxt   = '0;
      elapsed_nxt    = '0;
      echo_armed_nxt = 1'b0;
      receiving_nxt  = (start_len != '0);
      if (start_len == '0) begin
        rx_res.valid  = 1'b1;
        rx_res.count  = '0;
        rx_res.status = ST_CRC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RESET;
      rx_index_r   <= '0;
      awaited_r    <= '0;
      receiving_r  <= 1'b0;
      echo_armed_r <= 1'b0;
      elapsed_r    <= '0;
      lagged_crc_r <= CRC_INIT;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      rx_index_r   <= rx_index_nxt;
      awaited_r    <= awaited_nxt;
      receiving_r  <= receiving_nxt;
      echo_armed_r <= echo_armed_nxt;
      elapsed_r    <= elapsed_nxt;
      // restart the lagged CRC on every arm
      if (accept && (command == CMD_START || (command == CMD_SEND && check_echo))) begin
        lagged_crc_r <= CRC_INIT;
      end else begin
        lagged_crc_r <= lagged_crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    newest_r <= newest_nxt;
    older_r  <= older_nxt;
    if (wr_en) begin
      rx_store_r[rx_index_r[SLOT_W-1:0]] <= rx_byte;
    end
  end

endmodule

@@ rtl/mrfe_tx.sv @@
// Transmit sequencer and result register of the Modbus RTU master frame engine:
// builds the request frame, folds its CRC a byte per cycle unless the result port
// stalls, and drives that port. Depends on mrfe_pkg.
module mrfe_tx import mrfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [1:0] command,
  input  logic [15:0] station_addr,
  input  logic [7:0] function_code,
  input  logic [15:0] register_address,
  input  logic [15:0] write_value,
  input  rx_result_t rx_res,
  input  logic       out_stall,
  output frame_t     sent_frame,
  output logic       busy,
  output logic       out_valid,
  output logic       out_result_kind,
  output logic [7:0] out_tx_byte,
  output logic       out_last_of_frame,
  output logic [3:0] out_rx_count,
  output logic [1:0] out_status
);

  frame_t           sent_r;
  logic [15:0]      crc_run_r;
  logic [SEQ_W-1:0] seq_r;
  logic             valid_r;
  logic             kind_r;
  logic [7:0]       byte_r;
  logic             last_r;
  logic [3:0]       count_r;
  logic [1:0]       status_r;

  logic             load_ok;
  logic [7:0]       addr_byte;
  logic [7:0]       seq_byte;

  assign load_ok = !valid_r || !out_stall;
  assign busy    = (seq_r != '0);

  assign addr_byte = (station_addr == ADDR_ALL_ONES || station_addr < ADDR_MIN ||
                      station_addr > ADDR_MAX) ? ADDR_DEFAULT : station_addr[7:0];

  always_comb begin
    if (seq_r == SEQ_W'(REQ_LEN - 2)) begin
      seq_byte = crc_run_r[7:0];
    end else if (seq_r == SEQ_W'(REQ_LEN - 1)) begin
      seq_byte = crc_run_r[15:8];
    end else begin
      seq_byte = sent_r[seq_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      priority if (busy && load_ok) begin
        valid_r <= 1'b1;
        seq_r   <= seq_r + SEQ_W'(1);
      end else if (accept && command == CMD_SEND) begin
        valid_r <= 1'b1;
        seq_r   <= SEQ_W'(1);
      end else if (rx_res.valid) begin
        valid_r <= 1'b1;
      end else if (load_ok) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (busy && load_ok) begin
      kind_r   <= KIND_TX;
      byte_r   <= seq_byte;
      last_r   <= (seq_r == SEQ_W'(REQ_LEN - 1));
      count_r  <= '0;
      status_r <= ST_OK;
      if (seq_r < SEQ_W'(REQ_LEN - 2)) begin
        crc_run_r <= crc_fold(crc_run_r, sent_r[seq_r]);
      end
      if (seq_r == SEQ_W'(REQ_LEN - 2)) begin
        sent_r[REQ_LEN-2] <= crc_run_r[7:0];
        sent_r[REQ_LEN-1] <= crc_run_r[15:8];
      end
    end else if (accept && command == CMD_SEND) begin
      sent_r[0] <= addr_byte;
      sent_r[1] <= function_code;
      sent_r[2] <= register_address[15:8];
      sent_r[3] <= register_address[7:0];
      sent_r[4] <= write_value[15:8];
      sent_r[5] <= write_value[7:0];
      crc_run_r <= crc_fold(CRC_INIT, addr_byte);
      kind_r    <= KIND_TX;
      byte_r    <= addr_byte;
      last_r    <= 1'b0;
      count_r   <= '0;
      status_r  <= ST_OK;
    end else if (rx_res.valid) begin
      kind_r   <= KIND_STATUS;
      byte_r   <= '0;
      last_r   <= 1'b1;
      count_r  <= 4'(rx_res.count);
      status_r <= rx_res.status;
    end
  end

  assign sent_frame        = sent_r;
  assign out_valid         = valid_r;
  assign out_result_kind   = kind_r;
  assign out_tx_byte       = byte_r;
  assign out_last_of_frame = last_r;
  assign out_rx_count      = count_r;
  assign out_status        = status_r;

endmodule

@@ rtl/modbus_rtu_master_frame_engine_unit.sv @@
// Top level of the Modbus RTU master frame engine.
// Instantiates mrfe_tx and mrfe_rx; depends on mrfe_pkg.
//
// A user of this block should know first: every request (send, start receive,
// received byte, millisecond tick) is taken in one cycle whenever the result
// register is free or being drained. A send request yields eight transmit
// results, the last one marked; the CRC-16/MODBUS of the request is folded
// one byte per cycle unless the result port stalls, as the frame goes out, so
// input stalls after a send while that sequencer runs. Every other request is
// handled in the cycle it is accepted and its status result, if any, appears
// in the result register on the next cycle. Received bytes are kept in an
// eight-entry byte store written in place, while the last two bytes are held
// aside so that the CRC of the earlier bytes is folded as each new byte lands;
// the status is decided as the final byte or the timing-out tick arrives. The
// tick timeout register resets to 500 and should only be written while the
// block is idle.
module modbus_rtu_master_frame_engine_unit import mrfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: tick timeout
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_station_addr,
  input  logic [7:0]  in_function_code,
  input  logic [15:0] in_register_address,
  input  logic [15:0] in_write_value,
  input  logic        in_check_echo,
  input  logic [3:0]  in_expect_length,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last_of_frame,
  output logic [3:0]  out_rx_count,
  output logic [1:0]  out_status
);

  logic       accept;
  logic       tx_busy;
  logic       res_valid;
  frame_t     sent_frame;
  rx_result_t rx_res;

  // Hold requests while the frame sequencer runs or the result register is blocked
  assign in_stall = tx_busy || (res_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign out_valid = res_valid;

  mrfe_rx u_rx (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .accept        (accept),
    .command       (in_command),
    .check_echo    (in_check_echo),
    .expect_length (in_expect_length),
    .rx_byte       (in_rx_byte),
    .sent_frame    (sent_frame),
    .rx_res        (rx_res)
  );

  mrfe_tx u_tx (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .command           (in_command),
    .station_addr      (in_station_addr),
    .function_code     (in_function_code),
    .register_address  (in_register_address),
    .write_value       (in_write_value),
    .rx_res            (rx_res),
    .out_stall         (out_stall),
    .sent_frame        (sent_frame),
    .busy              (tx_busy),
    .out_valid         (res_valid),
    .out_result_kind   (out_result_kind),
    .out_tx_byte       (out_tx_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_rx_count      (out_rx_count),
    .out_status        (out_status)
  );

endmodule

@@ tb/mrfe_frame_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the Modbus RTU master frame engine: watches the request, result and
// configuration ports, predicts every result and compares it field by field.
// Depends on mrfe_pkg for the command, status and result-kind codes.
module mrfe_frame_checker import mrfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_station_addr,
  input  logic [7:0]  in_function_code,
  input  logic [15:0] in_register_address,
  input  logic [15:0] in_write_value,
  input  logic        in_check_echo,
  input  logic [3:0]  in_expect_length,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_result_kind,
  input  logic [7:0]  out_tx_byte,
  input  logic        out_last_of_frame,
  input  logic [3:0]  out_rx_count,
  input  logic [1:0]  out_status,
  output int          mismatch_count,
  output int          pending_results,
  output int          results_checked
);

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_data;
    logic       last;
    logic [3:0] count;
    logic [1:0] status;
  } engine_result_t;

  engine_result_t awaited_results[$];

  logic [15:0] tick_limit;
  logic [7:0]  rx_bytes [MAX_FRAME];
  logic [7:0]  request_bytes [REQ_LEN];
  int          rx_fill;
  int          rx_target;
  logic        rx_armed;
  logic        echo_check;
  logic [15:0] ticks_run;
  logic [15:0] crc_behind;
  int          failures;
  int          checked;

  function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = (c >> 1) ^ (c[0] ? 16'hA001 : 16'h0000);
    return c;
  endfunction

  task automatic arm_receive(input int len, input logic echo);
    rx_armed   = 1'b1;
    echo_check = echo;
    rx_target  = len;
    rx_fill    = 0;
    ticks_run  = '0;
    crc_behind = 16'hFFFF;
  endtask

  // Decide the status of the receive in progress and queue it.
  task automatic close_receive();
    logic           crc_good;
    engine_result_t verdict;
    crc_good = 1'b0;
    if (rx_fill > 2 && rx_fill <= MAX_FRAME) begin
      crc_good = ({rx_bytes[rx_fill-1], rx_bytes[rx_fill-2]} == crc_behind);
    end
    verdict.kind    = KIND_STATUS;
    verdict.tx_data = 8'h00;
    verdict.last    = 1'b1;
    verdict.count   = crc_good ? 4'(rx_fill) : 4'd0;
    if (rx_fill < rx_target) begin
      verdict.status = ST_SHORT;
    end else if (!crc_good) begin
      verdict.status = ST_CRC;
    end else if (echo_check) begin
      verdict.status = ST_OK;
      if (rx_fill != REQ_LEN) begin
        verdict.status = ST_ECHO;
      end else begin
        for (int i = 0; i < REQ_LEN && i < MAX_FRAME; i++) begin
          if (rx_bytes[i] != request_bytes[i]) verdict.status = ST_ECHO;
        end
      end
    end else begin
      verdict.status = ST_OK;
    end
    rx_armed   = 1'b0;
    echo_check = 1'b0;
    awaited_results.push_back(verdict);
  endtask

  always @(posedge clk) begin : engine_model
    engine_result_t want;
    logic [15:0]    station;
    logic [15:0]    crc;
    int             len;
    if (!rst_n) begin
      tick_limit = TIMEOUT_RESET;
      rx_fill    = 0;
      rx_target  = 0;
      rx_armed   = 1'b0;
      echo_check = 1'b0;
      ticks_run  = '0;
      crc_behind = 16'hFFFF;
      awaited_results.delete();
    end else begin
      if (cfg_wr_en) tick_limit = cfg_wr_data;

      // Results first: anything leaving now was caused by an earlier request.
      if (out_valid && !out_stall) begin
        checked++;
        if (awaited_results.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("unexpected result: kind %0d byte %02h last %0d count %0d status %0d",
                     out_result_kind, out_tx_byte, out_last_of_frame, out_rx_count, out_status);
          end
        end else begin
          want = awaited_results.pop_front();
          if (want.kind !== out_result_kind || want.tx_data !== out_tx_byte ||
              want.last !== out_last_of_frame || want.count !== out_rx_count ||
              want.status !== out_status) begin
            failures++;
            if (failures <= 10) begin
              $display("result %0d: expected kind %0d byte %02h last %0d count %0d status %0d",
                       checked, want.kind, want.tx_data, want.last, want.count, want.status);
              $display("result %0d:      got kind %0d byte %02h last %0d count %0d status %0d",
                       checked, out_result_kind, out_tx_byte, out_last_of_frame, out_rx_count,
                       out_status);
            end
          end
        end
      end

      if (in_valid && !in_stall) begin
        case (in_command)
          CMD_SEND: begin
            station = in_station_addr;
            if (station == ADDR_ALL_ONES || station < ADDR_MIN || station > ADDR_MAX) begin
              station = {8'h00, ADDR_DEFAULT};
            end
            request_bytes[0] = station[7:0];
            request_bytes[1] = in_function_code;
            request_bytes[2] = in_register_address[15:8];
            request_bytes[3] = in_register_address[7:0];
            request_bytes[4] = in_write_value[15:8];
            request_bytes[5] = in_write_value[7:0];
            crc = 16'hFFFF;
            for (int i = 0; i < 6; i++) crc = modbus_crc_step(crc, request_bytes[i]);
            request_bytes[6] = crc[7:0];
            request_bytes[7] = crc[15:8];
            for (int i = 0; i < REQ_LEN; i++) begin
              want.kind    = KIND_TX;
              want.tx_data = request_bytes[i];
              want.last    = (i == REQ_LEN - 1);
              want.count   = 4'd0;
              want.status  = ST_OK;
              awaited_results.push_back(want);
            end
            // a send drops any receive in progress without a status
            rx_armed   = 1'b0;
            echo_check = 1'b0;
            if (in_check_echo) arm_receive(RX_CAP, 1'b1);
          end
          CMD_START: begin
            len = int'(in_expect_length);
            if (len > RX_CAP) len = RX_CAP;
            arm_receive(len, 1'b0);
            if (rx_target == 0) close_receive();
          end
          CMD_BYTE: begin
            if (rx_armed) begin
              if (rx_fill >= rx_target || rx_fill >= MAX_FRAME) begin
                close_receive();
              end else begin
                if (rx_fill >= 2) crc_behind = modbus_crc_step(crc_behind, rx_bytes[rx_fill-2]);
                rx_bytes[rx_fill] = in_rx_byte;
                rx_fill++;
                if (rx_fill >= rx_target) close_receive();
              end
            end
          end
          default: begin
            if (rx_armed) begin
              if (ticks_run != 16'hFFFF) ticks_run++;
              if (ticks_run >= tick_limit) close_receive();
            end
          end
        endcase
      end
    end
    mismatch_count  <= failures;
    pending_results <= awaited_results.size();
    results_checked <= checked;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the testbench for the Modbus RTU master frame engine: clock, reset, request
// and configuration stimulus, result-port stalls and the final verdict.
// Depends on mrfe_pkg, modbus_rtu_master_frame_engine_unit and mrfe_frame_checker.
module tb_top;
  import mrfe_pkg::*;

  // Far beyond the slowest correct run: a few hundred requests, a send costing
  // eight results that may each wait out a long stall.
  localparam int CYCLE_LIMIT   = 400000;
  // Idle cycles let pass before a register write and before the verdict; a send
  // keeps the result port busy for its eight results.
  localparam int SETTLE_CYCLES = 16;

  logic        clk                 = 1'b0;
  logic        rst_n               = 1'b0;
  logic        cfg_wr_en           = 1'b0;
  logic [15:0] cfg_wr_data         = '0;
  logic        in_valid            = 1'b0;
  logic [1:0]  in_command          = CMD_TICK;
  logic [15:0] in_station_addr     = '0;
  logic [7:0]  in_function_code    = '0;
  logic [15:0] in_register_address = '0;
  logic [15:0] in_write_value      = '0;
  logic        in_check_echo       = 1'b0;
  logic [3:0]  in_expect_length    = '0;
  logic [7:0]  in_rx_byte          = '0;
  logic        out_stall           = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic        out_result_kind;
  logic [7:0]  out_tx_byte;
  logic        out_last_of_frame;
  logic [3:0]  out_rx_count;
  logic [1:0]  out_status;

  int mismatch_count;
  int pending_results;
  int results_checked;

  modbus_rtu_master_frame_engine_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_station_addr     (in_station_addr),
    .in_function_code    (in_function_code),
    .in_register_address (in_register_address),
    .in_write_value      (in_write_value),
    .in_check_echo       (in_check_echo),
    .in_expect_length    (in_expect_length),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_tx_byte         (out_tx_byte),
    .out_last_of_frame   (out_last_of_frame),
    .out_rx_count        (out_rx_count),
    .out_status          (out_status)
  );

  mrfe_frame_checker checker_u (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_station_addr     (in_station_addr),
    .in_function_code    (in_function_code),
    .in_register_address (in_register_address),
    .in_write_value      (in_write_value),
    .in_check_echo       (in_check_echo),
    .in_expect_length    (in_expect_length),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_tx_byte         (out_tx_byte),
    .out_last_of_frame   (out_last_of_frame),
    .out_rx_count        (out_rx_count),
    .out_status          (out_status),
    .mismatch_count      (mismatch_count),
    .pending_results     (pending_results),
    .results_checked     (results_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side. The stall pattern steps through four phases: no stall, sparse
  // random stalls, a fixed three-in-eight beat, and heavy random stalling.
  // Transmit bytes are kept so that a send can be echoed back like a remote
  // station would; statuses are tallied for the closing summary.
  logic [7:0] echo_buf [REQ_LEN];
  int         echo_fill         = 0;
  int         stall_clock       = 0;
  int         status_tally [4]  = '{default: 0};

  always @(posedge clk) begin
    stall_clock <= stall_clock + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
      echo_fill <= 0;
    end else begin
      case (stall_clock[8:7])
        2'd0:    out_stall <= 1'b0;
        2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
        2'd2:    out_stall <= (stall_clock[2:0] < 3);
        default: out_stall <= ($urandom_range(0, 9) < 6);
      endcase
      if (out_valid && !out_stall) begin
        if (out_result_kind == KIND_TX) begin
          echo_buf[echo_fill % REQ_LEN] <= out_tx_byte;
          echo_fill <= echo_fill + 1;
        end else begin
          status_tally[out_status] <= status_tally[out_status] + 1;
        end
      end
    end
  end

  // Request side.
  int         burst_left     = 0;
  int         requests_taken = 0;
  int         noise_taken    = 0;
  logic [7:0] frame_buf [REQ_LEN];

  // Offer one request and hold it until taken. The sender works in bursts:
  // when a burst runs out it usually drops valid for a random gap first.
  task automatic push_request(input logic [1:0] cmd, input logic [15:0] addr,
                              input logic [7:0] fc, input logic [15:0] reg_addr,
                              input logic [15:0] value, input logic echo,
                              input logic [3:0] len, input logic [7:0] rx_data);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid            <= 1'b1;
    in_command          <= cmd;
    in_station_addr     <= addr;
    in_function_code    <= fc;
    in_register_address <= reg_addr;
    in_write_value      <= value;
    in_check_echo       <= echo;
    in_expect_length    <= len;
    in_rx_byte          <= rx_data;
    do @(posedge clk); while (in_stall);
    burst_left--;
    requests_taken++;
  endtask

  // Fields a command does not use are filled at random so that every bit moves.
  task automatic send_cmd(input logic [15:0] addr, input logic [7:0] fc,
                          input logic [15:0] reg_addr, input logic [15:0] value,
                          input logic echo);
    push_request(CMD_SEND, addr, fc, reg_addr, value, echo, 4'($urandom), 8'($urandom));
  endtask

  task automatic start_cmd(input logic [3:0] len);
    push_request(CMD_START, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                 1'($urandom), len, 8'($urandom));
  endtask

  task automatic byte_cmd(input logic [7:0] rx_data);
    push_request(CMD_BYTE, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                 1'($urandom), 4'($urandom), rx_data);
  endtask

  task automatic tick_cmd();
    push_request(CMD_TICK, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                 1'($urandom), 4'($urandom), 8'($urandom));
  endtask

  // Drop valid and hold until every predicted result has left the block.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Append the CRC-16/MODBUS of the first n-2 bytes, low byte first.
  function automatic void seal_frame(input int n);
    logic [15:0] crc;
    crc = 16'hFFFF;
    for (int i = 0; i < n - 2; i++) begin
      crc ^= {8'h00, frame_buf[i]};
      repeat (8) crc = (crc >> 1) ^ (crc[0] ? 16'hA001 : 16'h0000);
    end
    frame_buf[n-2] = crc[7:0];
    frame_buf[n-1] = crc[15:8];
  endfunction

  // Feed n bytes of frame_buf to the receiver, now and then with a tick between
  // them so that timeouts land mid-frame when the limit is small.
  task automatic play_frame(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) tick_cmd();
      byte_cmd(frame_buf[i]);
    end
  endtask

  // Arm a receive and answer with n bytes, with a valid CRC when asked.
  task automatic receive_exchange(input logic [3:0] len, input int n, input bit good_crc);
    start_cmd(len);
    for (int i = 0; i < n; i++) frame_buf[i] = 8'($urandom);
    if (good_crc && n >= 3) seal_frame(n);
    play_frame(n);
  endtask

  // Send a request with echo checking, catch the eight bytes on the result port
  // and play them back: exact, with one bit flipped, as another valid frame, with
  // the station byte altered and resealed, or cut short.
  task automatic echo_exchange(input int mode, input logic [15:0] addr);
    int base;
    int pos;
    drain_results();
    base = echo_fill;
    send_cmd(addr, 8'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (echo_fill - base < REQ_LEN);
    for (int i = 0; i < REQ_LEN; i++) frame_buf[i] = echo_buf[(base + i) % REQ_LEN];
    case (mode)
      0: play_frame(REQ_LEN);
      1: begin
        pos = $urandom_range(0, REQ_LEN - 1);
        frame_buf[pos] ^= 8'(1 << $urandom_range(0, 7));
        play_frame(REQ_LEN);
      end
      2: begin
        for (int i = 0; i < 6; i++) frame_buf[i] = 8'($urandom);
        seal_frame(REQ_LEN);
        play_frame(REQ_LEN);
      end
      3: begin
        frame_buf[0] ^= 8'($urandom_range(1, 255));
        seal_frame(REQ_LEN);
        play_frame(REQ_LEN);
      end
      default: begin
        play_frame($urandom_range(0, REQ_LEN - 1));
        repeat ($urandom_range(0, 3)) tick_cmd();
      end
    endcase
  endtask

  // Change the tick limit with the block idle. A zero-length start first closes
  // any receive still armed, so no receive spans two settings.
  task automatic retune_timeout(input logic [15:0] ticks);
    start_cmd(4'd0);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly well-formed exchanges with random content; a fifth of the time a
  // short spray of fully random requests. Only requests outside the spray count
  // toward the quota.
  task automatic run_random(input int quota);
    int goal;
    int pick;
    int len;
    int cap;
    int n;
    goal = requests_taken - noise_taken + quota;
    while (requests_taken - noise_taken < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        pick = $urandom_range(0, 99);
        echo_exchange(pick < 55 ? 0 : pick < 65 ? 1 : pick < 75 ? 2 : pick < 87 ? 3 : 4,
                      ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 247)));
      end else if (pick < 65) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        cap = (len > RX_CAP) ? RX_CAP : len;
        n = ($urandom_range(0, 6) == 0 && cap > 0) ? $urandom_range(0, cap - 1) : cap;
        receive_exchange(4'(len), n, $urandom_range(0, 3) != 0);
        if (n < cap) begin
          repeat ($urandom_range(0, 4)) tick_cmd();
        end
      end else if (pick < 80) begin
        send_cmd(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_request(2'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                       16'($urandom), 1'($urandom), 4'($urandom), 8'($urandom));
          noise_taken++;
        end
      end
    end
  endtask

  int last_limit;

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with a three-tick limit.
    retune_timeout(16'd3);
    // address mapping: zero, all ones, just above the top station
    send_cmd(16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0);
    send_cmd(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_cmd(16'h00F8, 8'h10, 16'h8001, 16'h7FFE, 1'b0);
    // byte and tick with nothing armed: ignored
    byte_cmd(8'hA5);
    tick_cmd();
    // zero length ends at once; an oversized length is cut to the frame size
    // and then restarted by a second start
    start_cmd(4'd0);
    start_cmd(4'd15);
    receive_exchange(4'd3, 3, 1'b1);
    // one byte of four, then the tick limit runs out
    receive_exchange(4'd4, 1, 1'b0);
    repeat (3) tick_cmd();
    // top station, clean echo
    echo_exchange(0, 16'h00F7);

    // Random part over several limits: every tick ends a receive, ticks never
    // matter, and a small random limit.
    retune_timeout(16'd1);
    run_random(85);
    retune_timeout(16'hFFFF);
    run_random(90);
    last_limit = $urandom_range(2, 12);
    retune_timeout(16'(last_limit));
    run_random(90);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d requests taken (%0d random noise), %0d results checked,",
             requests_taken, noise_taken, results_checked);
    $display("tick limits 3/1/65535/%0d; statuses seen: ok %0d, short %0d, crc %0d, echo %0d",
             last_limit, status_tally[ST_OK], status_tally[ST_SHORT], status_tally[ST_CRC],
             status_tally[ST_ECHO]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
